// ----- rtl/ftm_pkg.sv -----
// Package for the filmic tone map unit: formats, curve coefficients, reset value.
// Used by every module in rtl/.
package ftm_pkg;
   localparam int unsigned CHAN_W    = 32;
   localparam int unsigned GAIN_W    = 16;
   localparam int unsigned OUT_W     = 17;
   localparam int unsigned X_W       = 20;
   localparam int unsigned NUM_W     = 44;
   localparam int unsigned DEN_W     = 44;
   localparam int unsigned DIV_STEPS = 18;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;
   localparam logic [17:0] COEF_A = 18'd164495;
   localparam logic [10:0] COEF_B = 11'd1966;
   localparam logic [17:0] COEF_C = 18'd159252;
   localparam logic [15:0] COEF_D = 16'd38666;
   localparam logic [13:0] COEF_E = 14'd9175;
   localparam logic [OUT_W-1:0] ONE_Q16 = 17'd65536;

   // Data handed from one divider cell to the next
   typedef struct packed {
      logic              valid;
      logic              sat;
      logic              last;
      logic [NUM_W+16:0] rem;
      logic [DEN_W-1:0]  den;
      logic [OUT_W:0]    quo;
   } div_lane_type;
endpackage

// ----- rtl/filmic_tone_map_rgb_unit.sv -----
// ACES filmic tone map, three channels side by side.
// Pipeline from start to rsp_valid: 4 front-end stages, 18 divider cells, one
// output register. Throughput: one pixel per cycle; busy stays low.
// Reset: synchronous, clears the pipeline valids and sets exposure gain to 1.0.
// The receiver cannot stall; each result shows for one cycle under rsp_valid.
module filmic_tone_map_rgb_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ftm_pkg::CHAN_W-1:0] req_red_in,
   input  logic [ftm_pkg::CHAN_W-1:0] req_green_in,
   input  logic [ftm_pkg::CHAN_W-1:0] req_blue_in,
   input  logic                       req_last_pixel_in,
   output logic                       rsp_valid,
   output logic [ftm_pkg::OUT_W-1:0]  rsp_red_out,
   output logic [ftm_pkg::OUT_W-1:0]  rsp_green_out,
   output logic [ftm_pkg::OUT_W-1:0]  rsp_blue_out,
   output logic                       rsp_last_pixel_out,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [ftm_pkg::GAIN_W-1:0] csr_data
);
   import ftm_pkg::*;

   logic [GAIN_W-1:0] gain_ff;
   logic              take;
   logic [2:0]        v;
   logic [2:0]        l;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start && !busy;

   // Hold the exposure gain
   always_ff @(posedge clock) begin
      if (reset)          gain_ff <= GAIN_RESET;
      else if (csr_valid) gain_ff <= csr_data;
   end

   ftm_channel u_red (.clock, .reset, .valid_in(take), .last_in(req_last_pixel_in),
      .chan_in(req_red_in), .gain_in(gain_ff), .valid_out(v[0]), .last_out(l[0]),
      .chan_out(rsp_red_out));
   ftm_channel u_green (.clock, .reset, .valid_in(take), .last_in(req_last_pixel_in),
      .chan_in(req_green_in), .gain_in(gain_ff), .valid_out(v[1]), .last_out(l[1]),
      .chan_out(rsp_green_out));
   ftm_channel u_blue (.clock, .reset, .valid_in(take), .last_in(req_last_pixel_in),
      .chan_in(req_blue_in), .gain_in(gain_ff), .valid_out(v[2]), .last_out(l[2]),
      .chan_out(rsp_blue_out));

   assign rsp_valid          = v[0];
   assign rsp_last_pixel_out = l[0];

   // Channels run in lockstep
   a_lockstep: assert property (@(posedge clock) disable iff (reset)
      v[0] == v[1] && v[1] == v[2]) else $error("channel valids diverged");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> l[0] == l[1] && l[1] == l[2]) else $error("channel flags diverged");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_red_out <= ONE_Q16 && rsp_green_out <= ONE_Q16 &&
                    rsp_blue_out <= ONE_Q16)
      else $error("result above one");
   a_gain: assert property (@(posedge clock) disable iff (reset)
      !$past(csr_valid) |-> $stable(gain_ff)) else $error("gain changed");
endmodule

// ----- rtl/ftm_front.sv -----
// Front end for one channel: exposure, saturation, numerator and denominator.
// Depends on ftm_pkg. Four register stages.
module ftm_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      valid_in,
   input  logic [ftm_pkg::CHAN_W-1:0] chan_in,
   input  logic [ftm_pkg::GAIN_W-1:0] gain_in,
   output logic                      valid_out,
   output logic                      sat_out,
   output logic [ftm_pkg::NUM_W-1:0] num_out,
   output logic [ftm_pkg::DEN_W-1:0] den_out
);
   import ftm_pkg::*;

   logic [3:0]        vld_ff;
   logic [47:0]       prod_ff;
   logic              sat1_ff, sat2_ff, sat3_ff;
   logic [X_W-1:0]    x1_ff, x2_ff;
   logic [39:0]       t1_ff, t2_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [39:0]       p_in;
   logic [59:0]       n_in, d_in;

   // Valid shift line
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else       vld_ff <= {vld_ff[2:0], valid_in};
   end

   // Stage 1: exposure product
   always_ff @(posedge clock) begin
      prod_ff <= chan_in * gain_in;
   end

   // Stage 2: scale, saturate, detect the flat top of the curve
   assign p_in = prod_ff[47:8];
   always_ff @(posedge clock) begin
      sat1_ff <= (p_in >= 40'(32'd16 << 16));
      x1_ff   <= p_in[X_W-1:0];
   end

   // Stage 3: linear terms
   always_ff @(posedge clock) begin
      sat2_ff <= sat1_ff;
      x2_ff   <= x1_ff;
      t1_ff   <= 40'(COEF_A) * 40'(x1_ff) + 40'({COEF_B, 16'd0});
      t2_ff   <= 40'(COEF_C) * 40'(x1_ff) + 40'({COEF_D, 16'd0});
   end

   // Stage 4: quadratic terms truncated to Q.32
   assign n_in = x2_ff * t1_ff;
   assign d_in = x2_ff * t2_ff + 60'({COEF_E, 32'd0});
   always_ff @(posedge clock) begin
      sat3_ff <= sat2_ff;
      num_ff  <= n_in[NUM_W+15:16];
      den_ff  <= d_in[DEN_W+15:16];
   end

   assign valid_out = vld_ff[3];
   assign sat_out   = sat3_ff;
   assign num_out   = num_ff;
   assign den_out   = den_ff;
endmodule

// ----- rtl/ftm_div_cell.sv -----
// One restoring-division cell: retires one quotient bit and passes on.
// Depends on ftm_pkg.
module ftm_div_cell #(
   parameter int unsigned BIT_POS = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ftm_pkg::div_lane_type lane_in,
   output ftm_pkg::div_lane_type lane_out
);
   import ftm_pkg::*;

   div_lane_type lane_ff;
   logic [NUM_W+16:0] trial_in;
   logic              fits_in;

   // Compare remainder against the shifted divisor
   assign trial_in = (NUM_W+17)'(lane_in.den) << BIT_POS;
   assign fits_in  = lane_in.rem >= trial_in;

   // Advance the item to the next cell
   always_ff @(posedge clock) begin
      if (reset) lane_ff.valid <= 1'b0;
      else       lane_ff.valid <= lane_in.valid;
      lane_ff.sat  <= lane_in.sat;
      lane_ff.last <= lane_in.last;
      lane_ff.den  <= lane_in.den;
      lane_ff.rem  <= fits_in ? lane_in.rem - trial_in : lane_in.rem;
      lane_ff.quo  <= lane_in.quo | ((OUT_W+1)'(fits_in) << BIT_POS);
   end

   assign lane_out = lane_ff;
endmodule

// ----- rtl/ftm_channel.sv -----
// One channel: front end, then a chain of divider cells, then clamp.
// Depends on ftm_pkg, ftm_front, ftm_div_cell.
module ftm_channel (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       valid_in,
   input  logic                       last_in,
   input  logic [ftm_pkg::CHAN_W-1:0] chan_in,
   input  logic [ftm_pkg::GAIN_W-1:0] gain_in,
   output logic                       valid_out,
   output logic                       last_out,
   output logic [ftm_pkg::OUT_W-1:0]  chan_out
);
   import ftm_pkg::*;

   logic              f_valid, f_sat;
   logic [NUM_W-1:0]  f_num;
   logic [DEN_W-1:0]  f_den;
   logic [3:0]        last_ff;
   div_lane_type      lane [DIV_STEPS+1];
   logic [OUT_W-1:0]  res_ff;
   logic              vld_ff, lst_ff;

   ftm_front u_front (
      .clock, .reset, .valid_in, .chan_in, .gain_in,
      .valid_out(f_valid), .sat_out(f_sat), .num_out(f_num), .den_out(f_den)
   );

   // Carry the flag alongside the front end
   always_ff @(posedge clock) begin
      last_ff <= {last_ff[2:0], last_in};
   end

   // Seed the chain with the rounded dividend
   always_comb begin
      lane[0].valid = f_valid;
      lane[0].sat   = f_sat;
      lane[0].last  = last_ff[3];
      lane[0].den   = f_den;
      lane[0].rem   = {f_num, 16'd0} + (NUM_W+17)'(f_den >> 1);
      lane[0].quo   = '0;
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
      ftm_div_cell #(.BIT_POS(DIV_STEPS-1-i)) u_cell (
         .clock, .reset, .lane_in(lane[i]), .lane_out(lane[i+1])
      );
   end

   // Clamp and register the result
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= lane[DIV_STEPS].valid;
      lst_ff <= lane[DIV_STEPS].last;
      if (lane[DIV_STEPS].sat || lane[DIV_STEPS].quo > (OUT_W+1)'(ONE_Q16))
         res_ff <= ONE_Q16;
      else
         res_ff <= lane[DIV_STEPS].quo[OUT_W-1:0];
   end

   assign valid_out = vld_ff;
   assign last_out  = lst_ff;
   assign chan_out  = res_ff;
endmodule
